FILE: rtl/tmpc_pkg.sv
package tmpc_pkg;

  localparam int SAMPLE_W       = 10;
  localparam int SUM_W          = 16;
  localparam int CNT_W          = 7;
  localparam int MAX_SAMPLES    = 64;
  localparam int TRIM_MIN_COUNT = 5;
  localparam int MEAN_FRAC_W    = 8;
  localparam int DVD_W          = SUM_W + MEAN_FRAC_W;
  localparam int DVS_W          = CNT_W;
  localparam int DIV_CNT_W      = $clog2(DVD_W);
  localparam int MEAN_W         = 18;
  localparam int MEAN_WIDE_W    = DVD_W + MEAN_FRAC_W;
  localparam int OFS_W          = 15;
  localparam int PH_W           = 16;
  localparam int PH_SCALE       = 17500;
  localparam int PH_SCALE_W     = 15;
  localparam int PH_SHIFT       = 18;
  localparam int PROD_W         = MEAN_W + PH_SCALE_W;
  localparam int PH_BASE_W      = PROD_W - PH_SHIFT;
  localparam int PH_SUM_W       = PH_W + 1;

  localparam logic [PROD_W-1:0]   PH_ROUND = PROD_W'(1) << (PH_SHIFT - 1);
  localparam logic [MEAN_W-1:0]   MEAN_MAX = {MEAN_W{1'b1}};
  localparam logic [PH_SUM_W-1:0] PH_POS_MAX = PH_SUM_W'((1 << (PH_W - 1)) - 1);
  localparam logic [PH_SUM_W-1:0] PH_NEG_MIN = PH_SUM_W'(-(1 << (PH_W - 1)));

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_MEAN,
    ST_MUL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0] min;
    logic [SAMPLE_W-1:0] max;
    logic [CNT_W-1:0]    count;
    logic                overflow;
  } batch_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

endpackage

FILE: rtl/tmpc_batch.sv
module tmpc_batch (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [tmpc_pkg::SAMPLE_W-1:0]  sample,
  input  logic                           clear,
  output tmpc_pkg::batch_t               batch
);
  import tmpc_pkg::*;

  batch_t batch_r;
  batch_t batch_nxt;

  always_comb begin
    batch_nxt = batch_r;
    if (clear) begin
      batch_nxt = '0;
    end else if (accept) begin
      if (batch_r.count < CNT_W'(MAX_SAMPLES)) begin
        if (batch_r.count == '0) begin
          batch_nxt.min = sample;
          batch_nxt.max = sample;
        end else begin
          if (sample < batch_r.min) begin
            batch_nxt.min = sample;
          end
          if (sample > batch_r.max) begin
            batch_nxt.max = sample;
          end
        end
        batch_nxt.sum   = batch_r.sum + SUM_W'(sample);
        batch_nxt.count = batch_r.count + CNT_W'(1);
      end else begin
        batch_nxt.overflow = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_r <= '0;
    end else begin
      batch_r <= batch_nxt;
    end
  end

  assign batch = batch_r;

endmodule

FILE: rtl/tmpc_div.sv
module tmpc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tmpc_pkg::div_req_t          req,
  output logic [tmpc_pkg::DVD_W-1:0]  quotient,
  output logic                        done
);
  import tmpc_pkg::*;

  logic                 busy_r;
  logic                 busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_CNT_W-1:0] cnt_nxt;
  logic [DVS_W-1:0]     rem_r;
  logic [DVS_W-1:0]     rem_nxt;
  logic [DVD_W-1:0]     quo_r;
  logic [DVD_W-1:0]     quo_nxt;
  logic [DVS_W-1:0]     dvs_r;
  logic [DVS_W-1:0]     dvs_nxt;
  logic [DVS_W:0]       shifted;
  logic [DVS_W:0]       trial;

  assign shifted = {rem_r, quo_r[DVD_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};
  assign done    = busy_r && (cnt_r == DIV_CNT_W'(DVD_W - 1));

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (trial[DVS_W]) begin
        rem_nxt = shifted[DVS_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
      end else begin
        rem_nxt = trial[DVS_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient = quo_r;

endmodule

FILE: rtl/trimmed_mean_ph_converter.sv
// Trimmed-mean pH converter for batches of 10-bit probe samples.
// The input channel (in_valid, in_ready) carries one sample per transaction,
// and in_last_sample closes the batch. Samples that do not close a batch are
// taken one per cycle. Once 64 samples of a batch are counted, further samples
// are dropped and the overflow flag of the batch is set.
// After the closing transaction the block drops in_ready and runs a restoring
// divider, shared by the plain and the trimmed mean, one quotient bit per cycle,
// followed by the scaling multiply. The batch passes through the load, divide,
// mean, multiply and output states before the result transaction (out_valid,
// out_ready) shows up; no new batch is taken until the block is back in idle.
// The result sits in an output register; the next batch may start while it
// waits. If the receiver still stalls when the next result is ready, that
// result waits inside the block and in_ready stays low until it moves on.
// The calibration offset cfg_wdata is written whenever cfg_we is high and
// should only change while no batch is being closed.
// A synchronous active-low reset clears the batch, the offset and out_valid.
module trimmed_mean_ph_converter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [tmpc_pkg::SAMPLE_W-1:0]        in_sample,
  input  logic                                 in_last_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [tmpc_pkg::MEAN_W-1:0]          out_trimmed_mean,
  output logic signed [tmpc_pkg::PH_W-1:0]     out_ph_milli,
  output logic                                 out_overflow,
  input  logic                                 cfg_we,
  input  logic signed [tmpc_pkg::OFS_W-1:0]    cfg_wdata
);
  import tmpc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  batch_t           batch;
  div_req_t         div_req;
  logic [DVD_W-1:0] div_quot;
  logic             div_done;
  logic             in_accept;
  logic             batch_clear;
  logic             load_out;

  logic signed [OFS_W-1:0] ofs_r;
  logic                    short_r;
  logic                    short_nxt;
  logic                    zero_r;
  logic                    zero_nxt;
  logic                    ovf_r;
  logic                    ovf_nxt;
  logic [MEAN_W-1:0]       mean_r;
  logic [MEAN_W-1:0]       mean_nxt;
  logic [PROD_W-1:0]       prod_r;
  logic [PROD_W-1:0]       prod_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic [MEAN_W-1:0]       out_mean_r;
  logic signed [PH_W-1:0]  out_ph_r;
  logic                    out_ovf_r;

  logic [SUM_W-1:0]          trimmed;
  logic [DVS_W-1:0]          trim_div;
  logic [MEAN_WIDE_W-1:0]    mean_wide;
  logic [PROD_W-1:0]         prod_round;
  logic [PH_BASE_W-1:0]      ph_base;
  logic signed [PH_SUM_W-1:0] ph_sum;
  logic signed [PH_W-1:0]    ph_sat;

  assign in_accept = in_valid && in_ready;

  tmpc_batch u_batch (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .sample (in_sample),
    .clear  (batch_clear),
    .batch  (batch)
  );

  tmpc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .quotient (div_quot),
    .done     (div_done)
  );

  assign trimmed  = batch.sum - SUM_W'(batch.min) - SUM_W'(batch.max);
  assign trim_div = batch.count - DVS_W'(2);

  always_comb begin
    div_req.start    = (state_r == ST_LOAD);
    div_req.dividend = '0;
    div_req.divisor  = '0;
    if (short_nxt) begin
      div_req.dividend = DVD_W'(batch.sum);
      div_req.divisor  = batch.count;
    end else begin
      div_req.dividend = {trimmed, {MEAN_FRAC_W{1'b0}}} + DVD_W'(trim_div >> 1);
      div_req.divisor  = trim_div;
    end
  end

  always_comb begin
    if (short_r) begin
      mean_wide = {div_quot, {MEAN_FRAC_W{1'b0}}};
    end else begin
      mean_wide = MEAN_WIDE_W'(div_quot);
    end
    if (zero_r) begin
      mean_nxt = '0;
    end else if (mean_wide[MEAN_WIDE_W-1:MEAN_W] != '0) begin
      mean_nxt = MEAN_MAX;
    end else begin
      mean_nxt = mean_wide[MEAN_W-1:0];
    end
  end

  assign prod_nxt   = PROD_W'(mean_r) * PROD_W'(PH_SCALE);
  assign prod_round = prod_r + PH_ROUND;
  assign ph_base    = prod_round[PROD_W-1:PH_SHIFT];
  assign ph_sum     = $signed({{(PH_SUM_W - PH_BASE_W){1'b0}}, ph_base})
                    + PH_SUM_W'(ofs_r);

  always_comb begin
    if (ph_sum > $signed(PH_POS_MAX)) begin
      ph_sat = PH_W'(PH_POS_MAX);
    end else if (ph_sum < $signed(PH_NEG_MIN)) begin
      ph_sat = PH_W'(PH_NEG_MIN);
    end else begin
      ph_sat = ph_sum[PH_W-1:0];
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    batch_clear = 1'b0;
    load_out    = 1'b0;
    short_nxt   = short_r;
    zero_nxt    = zero_r;
    ovf_nxt     = ovf_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_last_sample) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        short_nxt   = batch.count < CNT_W'(TRIM_MIN_COUNT);
        zero_nxt    = batch.count == '0;
        ovf_nxt     = batch.overflow;
        batch_clear = 1'b1;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_MEAN;
        end
      end
      ST_MEAN: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = load_out || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ofs_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        ofs_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    short_r <= short_nxt;
    zero_r  <= zero_nxt;
    ovf_r   <= ovf_nxt;
    if (state_r == ST_MEAN) begin
      mean_r <= mean_nxt;
    end
    if (state_r == ST_MUL) begin
      prod_r <= prod_nxt;
    end
    if (load_out) begin
      out_mean_r <= mean_r;
      out_ph_r   <= ph_sat;
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_trimmed_mean = out_mean_r;
  assign out_ph_milli     = out_ph_r;
  assign out_overflow     = out_ovf_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    batch.count <= CNT_W'(MAX_SAMPLES))
    else $error("Batch count exceeds the sample limit.");

  a_close_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last_sample) |=> !in_ready)
    else $error("Input still ready after the closing transaction.");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("Divider finished outside the divide state.");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (batch.count != '0) |-> (batch.min <= batch.max))
    else $error("Batch minimum above batch maximum.");
`endif

endmodule
